@@ rtl/edmm_pkg.sv @@
// Shared types and constants for the event decision matrix matcher.
// No dependencies; used by edmm_row_cmp and event_decision_matrix_matcher_unit.
package edmm_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_MATCH = 2'd0;
    localparam logic [1:0] KIND_PROTO = 2'd1;
    localparam logic [1:0] KIND_NONE  = 2'd2;

    // Byte positions within one matrix row.
    localparam logic [2:0] OFS_ORIGIN  = 3'd0;
    localparam logic [2:0] OFS_FLAGS   = 3'd1;
    localparam logic [2:0] OFS_CMASK   = 3'd2;
    localparam logic [2:0] OFS_CFILTER = 3'd3;
    localparam logic [2:0] OFS_TMASK   = 3'd4;
    localparam logic [2:0] OFS_TFILTER = 3'd5;
    localparam logic [2:0] OFS_ACTION  = 3'd6;
    localparam logic [2:0] OFS_PARAM   = 3'd7;

    // Bit positions in the flags byte.
    localparam int FLAG_ENABLED = 7;
    localparam int FLAG_ORIGIN  = 6;
    localparam int FLAG_ZONE    = 4;
    localparam int FLAG_CMASK   = 1;
    localparam int FLAG_CFILTER = 0;

    // Zone value that addresses every node.
    localparam logic [7:0] ZONE_ALL = 8'hFF;

    // Most results given for one event, and the highest writable row count.
    localparam int MAX_RESULTS = 8;
    localparam int ADDR_ROWS   = 8;

    localparam logic [8:0] CLASS_PROTOCOL = 9'd0;

    typedef struct packed {
        logic [7:0] origin;
        logic [7:0] flags;
        logic [7:0] cmask;
        logic [7:0] cfilter;
        logic [7:0] tmask;
        logic [7:0] tfilter;
        logic [7:0] action;
        logic [7:0] param;
    } row_t;

    typedef struct packed {
        logic [8:0] cls;
        logic [7:0] typ;
        logic [7:0] origin;
        logic [7:0] zone;
    } evt_t;

endpackage

@@ rtl/edmm_row_cmp.sv @@
// Compare unit that checks one decision matrix row against the held event.
// Depends on edmm_pkg for the row and event types and the flag positions.
module edmm_row_cmp
    import edmm_pkg::*;
(
    input  row_t       row,
    input  evt_t       evt,
    input  logic [7:0] node_zone,
    output logic       match
);

    logic [8:0] cfilter9;
    logic [8:0] cmask9;
    logic       origin_ok;
    logic       zone_ok;
    logic       class_ok;
    logic       type_ok;

    // The class filter and mask take their ninth bit from the flags byte.
    assign cfilter9 = {row.flags[FLAG_CFILTER], row.cfilter};
    assign cmask9   = {row.flags[FLAG_CMASK], row.cmask};

    // Individual checks; origin and zone checks are optional per row.
    assign origin_ok = !row.flags[FLAG_ORIGIN] || (evt.origin == row.origin);
    assign zone_ok   = !row.flags[FLAG_ZONE] || (evt.zone == ZONE_ALL)
                       || (evt.zone == node_zone);
    assign class_ok  = ((cfilter9 ^ evt.cls) & cmask9) == 9'd0;
    assign type_ok   = ((row.tfilter ^ evt.typ) & row.tmask) == 8'd0;

    assign match = row.flags[FLAG_ENABLED] && origin_ok && zone_ok && class_ok && type_ok;

endmodule

@@ rtl/event_decision_matrix_matcher_unit.sv @@
// Top level of the event decision matrix matcher: row table, scan sequencer
// and result register. Depends on edmm_pkg and edmm_row_cmp.
//
// A byte write request gives no result. An event of protocol class gives its
// single result in the cycle after acceptance. Any other event is checked
// against the rows one row per cycle, while the result channel does not
// stall, through a single compare unit. It passes an accept step, then a scan
// step per stored row (ROWS, at most 8, since row_select reaches only rows 0
// to 7; rows above that are not stored), then a closing step that loads the
// final result, which is shown in the cycle after. Each match result is held
// back one step so that the final one can carry last; a stalled result
// channel stalls the scan. The next request is accepted only when the block
// is idle and its last result has been taken. The table resets to zero, so
// every row starts disabled.
module event_decision_matrix_matcher_unit
    import edmm_pkg::*;
#(
    parameter int ROWS = 8
) (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_cmd,
    input  logic [2:0] s_row_select,
    input  logic [2:0] s_byte_offset,
    input  logic [7:0] s_byte_value,
    input  logic [8:0] s_event_class,
    input  logic [7:0] s_event_type,
    input  logic [7:0] s_event_origin,
    input  logic [7:0] s_event_zone,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [2:0] m_hit_row,
    output logic [7:0] m_hit_action,
    output logic [7:0] m_hit_param,
    output logic       m_last
);

    localparam int STORED = (ROWS < ADDR_ROWS) ? ROWS : ADDR_ROWS;
    localparam int IDX_W  = (STORED > 1) ? $clog2(STORED) : 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [7:0]       node_zone_reg;
    logic [7:0]       rows_reg [STORED][8];
    evt_t             evt_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [2:0]       cnt_reg, cnt_next;

    logic             pend_valid_reg, pend_valid_next;
    logic [2:0]       pend_row_reg, pend_row_next;
    logic [7:0]       pend_action_reg, pend_action_next;
    logic [7:0]       pend_param_reg, pend_param_next;

    logic             m_valid_reg, m_valid_next;
    logic [1:0]       m_kind_reg, m_kind_next;
    logic [2:0]       m_hit_row_reg, m_hit_row_next;
    logic [7:0]       m_hit_action_reg, m_hit_action_next;
    logic [7:0]       m_hit_param_reg, m_hit_param_next;
    logic             m_last_reg, m_last_next;

    row_t             cur_row;
    logic             row_match;
    logic             out_free;
    logic             s_take;
    logic             row_write;

    // Configuration register is always writable.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_zone_reg <= 8'd0;
        end else if (cfg_valid) begin
            node_zone_reg <= cfg_data;
        end
    end

    // Handshake on the request side.
    assign s_ready   = (state_reg == ST_IDLE) && !m_valid_reg;
    assign s_take    = s_valid && s_ready;
    assign row_write = s_take && !s_cmd && (int'(s_row_select) < STORED);
    assign out_free  = !m_valid_reg || m_ready;

    // Row table, written one byte per request and cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < STORED; r++) begin
                for (int b = 0; b < 8; b++) begin
                    rows_reg[r][b] <= 8'd0;
                end
            end
        end else if (row_write) begin
            rows_reg[s_row_select[IDX_W-1:0]][s_byte_offset] <= s_byte_value;
        end
    end

    // Row under test this cycle.
    always_comb begin
        cur_row.origin  = rows_reg[idx_reg][OFS_ORIGIN];
        cur_row.flags   = rows_reg[idx_reg][OFS_FLAGS];
        cur_row.cmask   = rows_reg[idx_reg][OFS_CMASK];
        cur_row.cfilter = rows_reg[idx_reg][OFS_CFILTER];
        cur_row.tmask   = rows_reg[idx_reg][OFS_TMASK];
        cur_row.tfilter = rows_reg[idx_reg][OFS_TFILTER];
        cur_row.action  = rows_reg[idx_reg][OFS_ACTION];
        cur_row.param   = rows_reg[idx_reg][OFS_PARAM];
    end

    edmm_row_cmp u_row_cmp (
        .row       (cur_row),
        .evt       (evt_reg),
        .node_zone (node_zone_reg),
        .match     (row_match)
    );

    // Event capture at acceptance.
    always_ff @(posedge aclk) begin
        if (s_take && s_cmd) begin
            evt_reg.cls    <= s_event_class;
            evt_reg.typ    <= s_event_type;
            evt_reg.origin <= s_event_origin;
            evt_reg.zone   <= s_event_zone;
        end
    end

    // Scan sequencer with one held-back match and the result register.
    always_comb begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        cnt_next          = cnt_reg;
        pend_valid_next   = pend_valid_reg;
        pend_row_next     = pend_row_reg;
        pend_action_next  = pend_action_reg;
        pend_param_next   = pend_param_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_kind_next       = m_kind_reg;
        m_hit_row_next    = m_hit_row_reg;
        m_hit_action_next = m_hit_action_reg;
        m_hit_param_next  = m_hit_param_reg;
        m_last_next       = m_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_take && s_cmd) begin
                    if (s_event_class == CLASS_PROTOCOL) begin
                        m_valid_next      = 1'b1;
                        m_kind_next       = KIND_PROTO;
                        m_hit_row_next    = 3'd0;
                        m_hit_action_next = 8'd0;
                        m_hit_param_next  = 8'd0;
                        m_last_next       = 1'b1;
                    end else begin
                        idx_next        = '0;
                        cnt_next        = 3'd0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // A match with one already held must first push that one out.
                if (!row_match || !pend_valid_reg || out_free) begin
                    if (row_match) begin
                        if (pend_valid_reg) begin
                            m_valid_next      = 1'b1;
                            m_kind_next       = KIND_MATCH;
                            m_hit_row_next    = pend_row_reg;
                            m_hit_action_next = pend_action_reg;
                            m_hit_param_next  = pend_param_reg;
                            m_last_next       = 1'b0;
                        end
                        pend_valid_next  = 1'b1;
                        pend_row_next    = 3'(idx_reg);
                        pend_action_next = cur_row.action;
                        pend_param_next  = cur_row.param;
                        cnt_next         = cnt_reg + 3'd1;
                    end
                    if ((row_match && (cnt_reg == 3'(MAX_RESULTS - 1)))
                        || (idx_reg == IDX_W'(STORED - 1))) begin
                        state_next = ST_FINISH;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_last_next  = 1'b1;
                    if (pend_valid_reg) begin
                        m_kind_next       = KIND_MATCH;
                        m_hit_row_next    = pend_row_reg;
                        m_hit_action_next = pend_action_reg;
                        m_hit_param_next  = pend_param_reg;
                    end else begin
                        m_kind_next       = KIND_NONE;
                        m_hit_row_next    = 3'd0;
                        m_hit_action_next = 8'd0;
                        m_hit_param_next  = 8'd0;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            cnt_reg        <= 3'd0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        pend_row_reg     <= pend_row_next;
        pend_action_reg  <= pend_action_next;
        pend_param_reg   <= pend_param_next;
        m_kind_reg       <= m_kind_next;
        m_hit_row_reg    <= m_hit_row_next;
        m_hit_action_reg <= m_hit_action_next;
        m_hit_param_reg  <= m_hit_param_next;
        m_last_reg       <= m_last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = m_kind_reg;
    assign m_hit_row    = m_hit_row_reg;
    assign m_hit_action = m_hit_action_reg;
    assign m_hit_param  = m_hit_param_reg;
    assign m_last       = m_last_reg;

`ifndef ASSERT_OFF
    // Protocol and no-match results are always final and carry zero fields.
    a_nonmatch_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind != KIND_MATCH)) |->
            (m_last && (m_hit_row == 3'd0) && (m_hit_action == 8'd0)
             && (m_hit_param == 8'd0)))
        else $error("non-match result is not final or has nonzero fields");

    // A final result is only shown once the sequencer is idle and holds nothing.
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last) |-> ((state_reg == ST_IDLE) && !pend_valid_reg))
        else $error("final result shown while the scan is still active");

    // The scan index never leaves the stored rows.
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (int'(idx_reg) < STORED))
        else $error("scan index beyond the stored rows");

    // A protocol class event gives its result in the next cycle.
    a_proto_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_cmd && (s_event_class == CLASS_PROTOCOL)) |=>
            (m_valid && (m_kind == KIND_PROTO) && (state_reg == ST_IDLE)))
        else $error("protocol event did not give its result");
`endif

endmodule
